// ===== src/gda_pkg.sv =====
// Package for the Gregorian date arithmetic block: types, status codes and
// constants shared by the pipeline and its checker. No dependencies.
`default_nettype none
package gda_pkg;
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DATE  = 2'd1,
        ST_OUT_RANGE = 2'd2
    } t_status;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DIFF = 1'b1;

    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;

    // Month length, index 1..12; February has 29 days when leap is set.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            default:                   r = 5'd0;
        endcase
        return r;
    endfunction

    // Days before month m in a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/gregorian_date_arithmetic.sv =====
// Gregorian date add / difference pipeline, top level.
// Depends on gda_pkg.
//
//  channel | dir | fields
//  s_axis  | in  | tuser: kind; tdata: year, month, day, offset, other y/m/d
//  m_axis  | out | tdata: result year, month, day, day_count, status
//
// Eight register stages; a transaction can enter in every cycle while the output
// is not blocked.
// Constant divisions are reciprocal multiplies or compare-and-subtract steps.
// Stall: all stages advance on one enable; while a result waits unaccepted
// the whole pipe holds, so nothing is lost or repeated.
// Reset clears the valid bits only.
`default_nettype none
module gregorian_date_arithmetic #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [13:0] year, [17:14] month, [22:18] day, [45:23] offset_days,
    // [59:46] other_year, [63:60] other_month, [68:64] other_day, rest 0
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [13:0] result_year, [17:14] result_month, [22:18] result_day,
    // [44:23] day_count, [46:45] status, rest 0
    output logic [47:0]      m_axis_tdata
);
    import gda_pkg::*;

    localparam int NS = 8;
    // Last day number, computed at elaboration.
    localparam longint LASTP = longint'(MAX_YEAR);
    localparam longint LAST_DN = LASTP*365 + LASTP/4 - LASTP/100 + LASTP/400 - 1;
    localparam int DW = 27;   // day-number width for MAX_YEAR up to 65535 plus offset
    // floor(x/25) = (x*1311) >> 15, exact for x below 4096
    localparam int unsigned RECIP_25 = 1311;
    // floor(n/146097) = (n*30103606) >> 42, exact for n below 2**25
    localparam int unsigned RECIP_400Y = 30103606;
    // floor(x/1461) = (x*45934) >> 26, exact for x up to 36524
    localparam int unsigned RECIP_4Y = 45934;

    logic [NS-1:0] r_vld;
    logic          adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- field unpack
    logic [13:0] in_y, in_y2;
    logic [3:0]  in_m, in_m2;
    logic [4:0]  in_d, in_d2;
    logic signed [22:0] in_off;
    assign in_y   = s_axis_tdata[13:0];
    assign in_m   = s_axis_tdata[17:14];
    assign in_d   = s_axis_tdata[22:18];
    assign in_off = s_axis_tdata[45:23];
    assign in_y2  = s_axis_tdata[59:46];
    assign in_m2  = s_axis_tdata[63:60];
    assign in_d2  = s_axis_tdata[68:64];

    // Leap test on a 14-bit year; y/100 and y/400 go through y/4 and y/16 by 25.
    function automatic logic leap14(input logic [13:0] y);
        logic [22:0] h4;
        logic [20:0] h16;
        h4  = 23'(y[13:2]) * 23'(RECIP_25);
        h16 = 21'(y[13:4]) * 21'(RECIP_25);
        return (y[1:0] == 2'd0) &&
               ((y[13:2] != 12'(h4[22:15]) * 12'd25) ||
                (y[3:2] == 2'd0 && y[13:4] == 10'(h16[20:15]) * 10'd25));
    endfunction

    function automatic logic ok14(input logic [13:0] y, input logic [3:0] m,
                                  input logic [4:0] d, input logic leap);
        return (y != 14'd0) && (32'(y) <= MAX_YEAR) && (m >= 4'd1) && (m <= 4'd12)
            && (d != 5'd0) && (d <= month_days(m, leap));
    endfunction

    // Day-of-year part (0-based) of a date.
    function automatic logic [8:0] doy(input logic [3:0] m, input logic [4:0] d,
                                       input logic leap);
        logic [8:0] r;
        r = days_before(m) + 9'(d) - 9'd1;
        if (leap && m > 4'd2) r = r + 9'd1;
        return r;
    endfunction

    // Days before Jan 1 of year p+1.
    function automatic logic [DW-1:0] ybase(input logic [13:0] p);
        logic [22:0] h4;
        logic [20:0] h16;
        h4  = 23'(p[13:2]) * 23'(RECIP_25);
        h16 = 21'(p[13:4]) * 21'(RECIP_25);
        return DW'(p)*DW'(365) + DW'(p[13:2]) - DW'(h4[22:15]) + DW'(h16[20:15]);
    endfunction

    // ---------------- stage 1: validate, day-of-year
    logic s1_leap, s1_leap2;
    assign s1_leap  = leap14(in_y);
    assign s1_leap2 = leap14(in_y2);
    logic        r_s1_kind, r_s1_bad;
    logic [13:0] r_s1_p, r_s1_p2;
    logic [8:0]  r_s1_doy, r_s1_doy2;
    logic signed [22:0] r_s1_off;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind <= s_axis_tuser;
            r_s1_bad  <= !ok14(in_y, in_m, in_d, s1_leap) ||
                         (s_axis_tuser == KIND_DIFF && !ok14(in_y2, in_m2, in_d2, s1_leap2));
            r_s1_p    <= in_y - 14'd1;
            r_s1_p2   <= in_y2 - 14'd1;
            r_s1_doy  <= doy(in_m, in_d, s1_leap);
            r_s1_doy2 <= doy(in_m2, in_d2, s1_leap2);
            r_s1_off  <= in_off;
        end
    end

    // ---------------- stage 2: day numbers
    logic        r_s2_kind, r_s2_bad;
    logic signed [DW:0] r_s2_n, r_s2_n2;
    logic signed [22:0] r_s2_off;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_kind <= r_s1_kind;
            r_s2_bad  <= r_s1_bad;
            r_s2_n    <= $signed({1'b0, ybase(r_s1_p) + DW'(r_s1_doy)});
            r_s2_n2   <= $signed({1'b0, ybase(r_s1_p2) + DW'(r_s1_doy2)});
            r_s2_off  <= r_s1_off;
        end
    end

    // ---------------- stage 3: add / subtract, range check
    logic signed [DW+1:0] s3_sum, s3_dif;
    assign s3_sum = (DW+2)'(r_s2_n) + (DW+2)'(r_s2_off);
    assign s3_dif = (DW+2)'(r_s2_n) - (DW+2)'(r_s2_n2);
    logic          r_s3_kind;
    t_status       r_s3_st;
    logic [DW-1:0] r_s3_n;
    logic [21:0]   r_s3_cnt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_kind <= r_s2_kind;
            r_s3_n    <= s3_sum[DW-1:0];
            r_s3_cnt  <= 22'(s3_dif < 0 ? -s3_dif : s3_dif);
            if (r_s2_bad)
                r_s3_st <= ST_BAD_DATE;
            else if (r_s2_kind == KIND_ADD &&
                     (s3_sum < 0 || s3_sum > (DW+2)'(LAST_DN)))
                r_s3_st <= ST_OUT_RANGE;
            else
                r_s3_st <= ST_OK;
        end
    end

    // ---------------- stage 4: 400-year cycle count by reciprocal
    logic [51:0] s4_prod;
    assign s4_prod = 52'(r_s3_n) * 52'(RECIP_400Y);
    logic          r_s4_kind;
    t_status       r_s4_st;
    logic [DW-1:0] r_s4_n;
    logic [8:0]    r_s4_q400;
    logic [21:0]   r_s4_cnt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_kind <= r_s3_kind;
            r_s4_st   <= r_s3_st;
            r_s4_cnt  <= r_s3_cnt;
            r_s4_n    <= r_s3_n;
            r_s4_q400 <= s4_prod[50:42];
        end
    end

    // ---------------- stage 5: remainder in cycle, century by compares
    logic [17:0] s5_r0;
    logic [1:0]  s5_q100;
    logic [15:0] s5_r1;
    always_comb begin
        s5_r0 = 18'(r_s4_n - DW'(r_s4_q400) * DW'(DAYS_400));
        if (s5_r0 >= 18'(3*DAYS_100))
            s5_q100 = 2'd3;
        else if (s5_r0 >= 18'(2*DAYS_100))
            s5_q100 = 2'd2;
        else if (s5_r0 >= 18'(DAYS_100))
            s5_q100 = 2'd1;
        else
            s5_q100 = 2'd0;
        s5_r1 = 16'(s5_r0 - 18'(s5_q100) * 18'(DAYS_100));
    end
    logic          r_s5_kind;
    t_status       r_s5_st;
    logic [8:0]    r_s5_q400;
    logic [1:0]    r_s5_q100;
    logic [15:0]   r_s5_r1;
    logic [21:0]   r_s5_cnt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_kind <= r_s4_kind;
            r_s5_st   <= r_s4_st;
            r_s5_cnt  <= r_s4_cnt;
            r_s5_q400 <= r_s4_q400;
            r_s5_q100 <= s5_q100;
            r_s5_r1   <= s5_r1;
        end
    end

    // ---------------- stage 6: 4-year group by reciprocal
    logic [31:0] s6_prod;
    logic [5:0]  s6_q4;
    logic [10:0] s6_r2;
    assign s6_prod = 32'(r_s5_r1) * 32'(RECIP_4Y);
    assign s6_q4   = s6_prod[31:26];
    assign s6_r2   = 11'(r_s5_r1 - 16'(s6_q4) * 16'(DAYS_4));
    logic          r_s6_kind;
    t_status       r_s6_st;
    logic [8:0]    r_s6_q400;
    logic [1:0]    r_s6_q100;
    logic [5:0]    r_s6_q4;
    logic [10:0]   r_s6_r2;
    logic [21:0]   r_s6_cnt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s6_kind <= r_s5_kind;
            r_s6_st   <= r_s5_st;
            r_s6_cnt  <= r_s5_cnt;
            r_s6_q400 <= r_s5_q400;
            r_s6_q100 <= r_s5_q100;
            r_s6_q4   <= s6_q4;
            r_s6_r2   <= s6_r2;
        end
    end

    // ---------------- stage 7: year in group, year number, leap flag
    logic [1:0] s7_q1;
    logic [8:0] s7_r3;
    logic       s7_leap;
    always_comb begin
        if (r_s6_r2 >= 11'd1095)
            s7_q1 = 2'd3;
        else if (r_s6_r2 >= 11'd730)
            s7_q1 = 2'd2;
        else if (r_s6_r2 >= 11'd365)
            s7_q1 = 2'd1;
        else
            s7_q1 = 2'd0;
        s7_r3 = 9'(r_s6_r2 - 11'(s7_q1) * 11'd365);
        // last year of a 4-year group, not a plain century year
        s7_leap = (s7_q1 == 2'd3) && (r_s6_q4 != 6'd24 || r_s6_q100 == 2'd3);
    end
    logic          r_s7_kind;
    t_status       r_s7_st;
    logic [13:0]   r_s7_y;
    logic [8:0]    r_s7_r;
    logic          r_s7_leap;
    logic [21:0]   r_s7_cnt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s7_kind <= r_s6_kind;
            r_s7_st   <= r_s6_st;
            r_s7_cnt  <= r_s6_cnt;
            r_s7_r    <= s7_r3;
            r_s7_leap <= s7_leap;
            r_s7_y    <= 14'(17'(r_s6_q400) * 17'd400 + 17'(r_s6_q100) * 17'd100
                           + 17'(r_s6_q4) * 17'd4 + 17'(s7_q1) + 17'd1);
        end
    end

    // ---------------- stage 8: month / day, output register
    logic [3:0] s8_m;
    logic [8:0] s8_base;
    always_comb begin
        s8_m = 4'd1;
        s8_base = 9'd0;
        for (int k = 2; k <= 12; k++) begin
            if (r_s7_r >= days_before(4'(k)) + ((r_s7_leap && k > 2) ? 9'd1 : 9'd0)) begin
                s8_m = 4'(k);
                s8_base = days_before(4'(k)) + ((r_s7_leap && k > 2) ? 9'd1 : 9'd0);
            end
        end
    end
    logic ok8, add8;
    assign ok8  = (r_s7_st == ST_OK);
    assign add8 = (r_s7_kind == KIND_ADD);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            m_axis_tdata[13:0]  <= (ok8 && add8) ? r_s7_y : 14'd0;
            m_axis_tdata[17:14] <= (ok8 && add8) ? s8_m : 4'd0;
            m_axis_tdata[22:18] <= (ok8 && add8) ? 5'(r_s7_r - s8_base + 9'd1) : 5'd0;
            m_axis_tdata[44:23] <= (ok8 && !add8) ? r_s7_cnt : 22'd0;
            m_axis_tdata[46:45] <= r_s7_st;
            m_axis_tdata[47]    <= 1'b0;
        end
    end

    // ---------------- valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (adv)
            r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = r_vld[NS-1];
endmodule
`default_nettype wire

// ===== src/gda_checker.sv =====
// Port-level checker for gregorian_date_arithmetic, bound to the top level.
// Depends on gda_pkg.
`default_nettype none
module gda_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    import gda_pkg::*;

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[46:45] != 2'd3) else $error("bad status");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[46:45] != ST_OK |-> m_axis_tdata[44:0] == 45'd0)
        else $error("error result not zero");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[44:23] != 22'd0 |-> m_axis_tdata[22:0] == 23'd0)
        else $error("date and count both set");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for gregorian_date_arithmetic: date add and day difference.
// Depends on gda_pkg and the block's top level; no files or arguments are read.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gda_pkg::*;

    localparam int MAXY = 9999;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int N_RANDOM = 900;

    typedef struct packed {
        logic        kind;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] offset;
        logic [13:0] oyear;
        logic [3:0]  omonth;
        logic [4:0]  oday;
    } t_query;

    typedef struct packed {
        logic [13:0] ryear;
        logic [3:0]  rmonth;
        logic [4:0]  rday;
        logic [21:0] count;
        t_status     status;
    } t_answer;

    // Directed row: query, plus a typed answer when has_ans is set.
    typedef struct {
        t_query  q;
        bit      has_ans;
        t_answer a;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // year, month, day, offset_days, other_year, other_month, other_day
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // result_year, result_month, result_day, day_count, status

    t_answer answers_due[$];
    int      n_errors = 0;
    int      n_table_errors = 0;
    int      cycle_count = 0;
    bit      stim_done;
    bit      long_hold;
    bit      hold_done;

    gregorian_date_arithmetic i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- date predictor ----------------
    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_len(int y, int m);
        int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 0;
        if (m == 2 && leap_year(y)) return 29;
        return lens[m];
    endfunction

    function automatic bit valid_date(int y, int m, int d);
        return y >= 1 && y <= MAXY && m >= 1 && m <= 12 && d >= 1 && d <= month_len(y, m);
    endfunction

    function automatic longint day_number(int y, int m, int d);
        longint p;
        longint n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < m; k++) n += month_len(y, k);
        return n + d - 1;
    endfunction

    function automatic t_answer predict_date(t_query q);
        t_answer a;
        longint n, r, q400, q100, q4, q1, y, last, diff;
        int mm;
        a = '0;
        a.status = ST_OK;
        if (q.kind == KIND_ADD) begin
            if (!valid_date(q.year, q.month, q.day)) begin
                a.status = ST_BAD_DATE;
            end else begin
                n = day_number(q.year, q.month, q.day) + longint'($signed(q.offset));
                last = day_number(MAXY, 12, 31);
                if (n < 0 || n > last) begin
                    a.status = ST_OUT_RANGE;
                end else begin
                    q400 = n / DAYS_400;
                    r = n % DAYS_400;
                    q100 = r / DAYS_100;
                    if (q100 > 3) q100 = 3;
                    r -= q100 * DAYS_100;
                    q4 = r / DAYS_4;
                    r = r % DAYS_4;
                    q1 = r / 365;
                    if (q1 > 3) q1 = 3;
                    r -= q1 * 365;
                    y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
                    mm = 1;
                    while (mm < 12 && r >= month_len(int'(y), mm)) begin
                        r -= month_len(int'(y), mm);
                        mm++;
                    end
                    a.ryear = y[13:0];
                    a.rmonth = mm[3:0];
                    a.rday = r[4:0] + 5'd1;
                end
            end
        end else begin
            if (!valid_date(q.year, q.month, q.day) ||
                !valid_date(q.oyear, q.omonth, q.oday)) begin
                a.status = ST_BAD_DATE;
            end else begin
                diff = day_number(q.year, q.month, q.day) -
                       day_number(q.oyear, q.omonth, q.oday);
                if (diff < 0) diff = -diff;
                a.count = diff[21:0];
            end
        end
        return a;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_query mk(logic kind, int y, int m, int d, int off,
                                  int y2, int m2, int d2);
        t_query q;
        q.kind = kind;
        q.year = y[13:0];
        q.month = m[3:0];
        q.day = d[4:0];
        q.offset = off[22:0];
        q.oyear = y2[13:0];
        q.omonth = m2[3:0];
        q.oday = d2[4:0];
        return q;
    endfunction

    function automatic t_answer ans(int y, int m, int d, int cnt, t_status st);
        t_answer a;
        a.ryear = y[13:0];
        a.rmonth = m[3:0];
        a.rday = d[4:0];
        a.count = cnt[21:0];
        a.status = st;
        return a;
    endfunction

    // Mostly valid dates, sometimes anything the fields allow.
    function automatic t_query random_query();
        t_query q;
        int y, m;
        q.kind = 1'($urandom_range(1, 0));
        if ($urandom_range(9, 0) == 0) begin
            q.year = 14'($urandom); q.month = 4'($urandom); q.day = 5'($urandom);
        end else begin
            y = ($urandom_range(3, 0) == 0) ? $urandom_range(MAXY, 1) :
                ($urandom_range(1, 0) ? $urandom_range(30, 1) : $urandom_range(MAXY, MAXY - 30));
            m = $urandom_range(12, 1);
            q.year = y[13:0]; q.month = m[3:0];
            q.day = 5'($urandom_range(month_len(y, m), 1));
        end
        if ($urandom_range(9, 0) == 0) begin
            q.oyear = 14'($urandom); q.omonth = 4'($urandom); q.oday = 5'($urandom);
        end else begin
            y = $urandom_range(MAXY, 1);
            m = $urandom_range(12, 1);
            q.oyear = y[13:0]; q.omonth = m[3:0];
            q.oday = 5'($urandom_range(month_len(y, m), 1));
        end
        case ($urandom_range(3, 0))
            0: q.offset = 23'($urandom);
            1: q.offset = 23'($signed($urandom_range(800, 0)) - 400);
            2: q.offset = 23'($signed($urandom_range(80000, 0)) - 40000);
            default: q.offset = 23'($signed($urandom_range(7304116, 0)) - 3652058);
        endcase
        return q;
    endfunction

    // Drive one query, wait until it is accepted, then log the expected answer.
    task automatic send_query(t_query q, bit has_ans, t_answer a);
        t_answer p;
        p = predict_date(q);
        if (has_ans && p !== a) begin
            n_table_errors++;
            if (n_table_errors <= 10)
                $display("table row disagrees with predictor: q=%h row=%h pred=%h", q, a, p);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = q.kind;
        s_axis_tdata = {3'b0, q.oday, q.omonth, q.oyear, q.offset, q.day, q.month, q.year};
        do @(posedge i_clk); while (!s_axis_tready);
        answers_due.push_back(has_ans ? a : p);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic sender_gap();
        int g;
        g = $urandom_range(8, 0);
        repeat (g) @(negedge i_clk);
    endtask

    // ---------------- sender ----------------
    initial begin
        t_row rows[$];
        t_answer none;
        none = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        stim_done = 1'b0;
        long_hold = 1'b0;
        answers_due.delete();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{mk(KIND_ADD, 1, 1, 1, 0, 0, 0, 0), 1, ans(1, 1, 1, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 1, 1, 1, -1, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_OUT_RANGE)});
        rows.push_back('{mk(KIND_ADD, 9999, 12, 31, 0, 0, 0, 0), 1, ans(9999, 12, 31, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 9999, 12, 31, 1, 0, 0, 0), 1,
                         ans(0, 0, 0, 0, ST_OUT_RANGE)});
        rows.push_back('{mk(KIND_ADD, 9999, 12, 31, -3652058, 0, 0, 0), 1,
                         ans(1, 1, 1, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 1, 1, 1, 3652058, 16383, 15, 31), 1,
                         ans(9999, 12, 31, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 5000, 6, 15, -4194304, 0, 0, 0), 1,
                         ans(0, 0, 0, 0, ST_OUT_RANGE)});
        rows.push_back('{mk(KIND_ADD, 5000, 6, 15, 4194303, 0, 0, 0), 1,
                         ans(0, 0, 0, 0, ST_OUT_RANGE)});
        rows.push_back('{mk(KIND_ADD, 0, 1, 1, 5, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 16383, 15, 31, 0, 0, 0, 0), 1,
                         ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 2000, 0, 1, 0, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 2000, 13, 1, 0, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 2000, 1, 0, 0, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 1900, 2, 29, 0, 0, 0, 0), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_ADD, 2000, 2, 28, 1, 0, 0, 0), 1, ans(2000, 2, 29, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 2100, 2, 28, 1, 0, 0, 0), 1, ans(2100, 3, 1, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 2024, 3, 1, -1, 0, 0, 0), 1, ans(2024, 2, 29, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 1999, 12, 31, 1, 0, 0, 0), 1, ans(2000, 1, 1, 0, ST_OK)});
        rows.push_back('{mk(KIND_ADD, 2000, 12, 31, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(KIND_DIFF, 1, 1, 1, 0, 9999, 12, 31), 1,
                         ans(0, 0, 0, 3652058, ST_OK)});
        rows.push_back('{mk(KIND_DIFF, 9999, 12, 31, 4194303, 1, 1, 1), 1,
                         ans(0, 0, 0, 3652058, ST_OK)});
        rows.push_back('{mk(KIND_DIFF, 2000, 1, 1, 0, 2001, 1, 1), 1, ans(0, 0, 0, 366, ST_OK)});
        rows.push_back('{mk(KIND_DIFF, 2000, 1, 1, 0, 2000, 4, 31), 1,
                         ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_DIFF, 0, 1, 1, 0, 2000, 1, 1), 1, ans(0, 0, 0, 0, ST_BAD_DATE)});
        rows.push_back('{mk(KIND_DIFF, 1600, 2, 29, 0, 1700, 3, 1), 0, none});

        foreach (rows[i]) begin
            send_query(rows[i].q, rows[i].has_ans, rows[i].a);
            if (i % 3 == 0) sender_gap();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Long receiver hold while the sender streams into a full pipeline.
            if (i == 200) long_hold = 1'b1;
            if (i == 240) long_hold = 1'b0;
            // Drain pause: wait until every answer is back.
            if (i == 500) wait (answers_due.size() == 0);
            send_query(random_query(), 0, none);
            if (!(i >= 200 && i < 300) && !(i >= 600 && i < 650)) sender_gap();
        end
        stim_done = 1'b1;
    end

    // ---------------- receiver ready ----------------
    initial begin
        int g;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (m_axis_tready && !m_axis_tvalid) begin
                // keep ready until an output transaction lands
            end else begin
                g = (cycle_count % 2000 < 300) ? 0 : $urandom_range(8, 0);
                if (g == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[13:0], m_axis_tdata[17:14], m_axis_tdata[22:18],
                   m_axis_tdata[44:23], t_status'(m_axis_tdata[46:45])};
            if (answers_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected output transaction %h", m_axis_tdata);
            end else begin
                want = answers_due.pop_front();
                if (got !== want || m_axis_tdata[47] !== 1'b0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch: exp y=%0d m=%0d d=%0d cnt=%0d st=%0d",
                                 want.ryear, want.rmonth, want.rday, want.count, want.status);
                        $display("          got y=%0d m=%0d d=%0d cnt=%0d st=%0d",
                                 got.ryear, got.rmonth, got.rday, got.count, got.status);
                    end
                end
            end
        end
    end

    // ---------------- run control ----------------
    initial begin
        fork
            begin
                wait (stim_done && answers_due.size() == 0);
                repeat (20) @(posedge i_clk);
                if (n_errors == 0 && n_table_errors == 0 && answers_due.size() == 0)
                    $display("gregorian_date_arithmetic test passed");
                else
                    $display("gregorian_date_arithmetic test failed");
            end
            begin
                while (cycle_count < TIMEOUT_CYCLES) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                $display("gregorian_date_arithmetic test failed");
            end
        join_any
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/gda_pkg.sv
src/gregorian_date_arithmetic.sv
src/gda_checker.sv
sim/tb.sv
